[rtl/core/tspc_pkg.sv]
package tspc_pkg;

    // Header window and length counter
    localparam int unsigned HDR_BYTES = 82;
    localparam int unsigned POS_W     = 7;

    // Byte offsets of the fields that the decision looks at
    localparam logic [POS_W-1:0] OFS_ETYPE_HI = 7'd12;
    localparam logic [POS_W-1:0] OFS_ETYPE_LO = 7'd13;
    localparam logic [POS_W-1:0] OFS_TCI_HI   = 7'd14;
    localparam logic [POS_W-1:0] OFS_IP_PROTO = 7'd23;
    localparam logic [POS_W-1:0] OFS_UDP_BASE = 7'd16;   // dest port at 14 + IHL*4 + 2
    localparam logic [POS_W-1:0] HDR_LAST     = 7'd82;

    // Minimum lengths for each check
    localparam logic [POS_W-1:0] LEN_ETH      = 7'd14;
    localparam logic [POS_W-1:0] LEN_VLAN     = 7'd16;
    localparam logic [POS_W-1:0] LEN_IPV4     = 7'd34;
    localparam logic [POS_W-1:0] LEN_UDP_BASE = 7'd22;   // 14 + IHL*4 + 8

    // Protocol codes
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // Configuration register map
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_AVTP_TYPE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PCP_THRESH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_MATCH_PORT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_PRIORITY    = 8'd3;

    localparam logic [15:0] RST_AVTP_TYPE      = 16'h22F0;
    localparam logic [2:0]  RST_PCP_THRESH     = 3'd5;
    localparam logic [15:0] RST_UDP_MATCH_PORT = 16'd6000;
    localparam logic [3:0]  RST_TS_PRIORITY    = 4'd6;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic        is_time_sensitive;
        logic [3:0]  assigned_priority;
        logic [63:0] normal_total;
        logic [63:0] ts_total;
    } out_item_t;

    typedef struct packed {
        logic [15:0] avtp_type_value;
        logic [2:0]  pcp_threshold;
        logic [15:0] udp_match_port;
        logic [3:0]  ts_priority_value;
    } cfg_regs_t;

    // Header fields as seen once the current byte is taken in
    typedef struct packed {
        logic [15:0]      etype;
        logic [7:0]       tci_hi;     // also IPv4 version / IHL
        logic [7:0]       ip_proto;
        logic [15:0]      udp_dport;
        logic [POS_W-1:0] len;
    } hdr_fields_t;

    // Time-sensitive decision on the captured header fields
    function automatic logic classify(input hdr_fields_t h, input cfg_regs_t c);
        logic             ts;
        logic [3:0]       ihl;
        logic [POS_W-1:0] udp_end;
        ts      = 1'b0;
        ihl     = h.tci_hi[3:0];
        udp_end = LEN_UDP_BASE + {1'b0, ihl, 2'b00};
        if (h.len >= LEN_ETH) begin
            if (h.etype == c.avtp_type_value) begin
                ts = 1'b1;
            end
            else if (h.etype == ETYPE_VLAN) begin
                ts = (h.len >= LEN_VLAN) && (h.tci_hi[7:5] >= c.pcp_threshold);
            end
            else if (h.etype == ETYPE_IPV4) begin
                ts = (h.len >= LEN_IPV4) && (h.ip_proto == PROTO_UDP) &&
                     (udp_end <= h.len) && (h.udp_dport == c.udp_match_port);
            end
        end
        return ts;
    endfunction

endpackage

[rtl/core/tspc_hdr_capture.sv]
module tspc_hdr_capture
    import tspc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  in_item_t    item,
    output hdr_fields_t hdr
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      etype_reg;
    logic [7:0]       tci_hi_reg, proto_reg;
    logic [15:0]      dport_reg;
    logic [POS_W-1:0] udp_pos;
    logic             in_win;

    // UDP dest port position follows from the IHL byte, which arrives first
    assign udp_pos = OFS_UDP_BASE + {1'b0, tci_hi_reg[3:0], 2'b00};
    assign in_win  = (pos_reg < HDR_LAST);

    // Field view with this byte merged in
    always_comb
    begin
        hdr.etype     = etype_reg;
        hdr.tci_hi    = tci_hi_reg;
        hdr.ip_proto  = proto_reg;
        hdr.udp_dport = dport_reg;
        hdr.len       = in_win ? pos_reg + 7'd1 : pos_reg;
        if (in_win)
        begin
            if (pos_reg == OFS_ETYPE_HI) hdr.etype[15:8]    = item.frame_byte;
            if (pos_reg == OFS_ETYPE_LO) hdr.etype[7:0]     = item.frame_byte;
            if (pos_reg == OFS_TCI_HI)   hdr.tci_hi         = item.frame_byte;
            if (pos_reg == OFS_IP_PROTO) hdr.ip_proto       = item.frame_byte;
            if (pos_reg >= OFS_UDP_BASE && pos_reg == udp_pos)
                hdr.udp_dport[15:8] = item.frame_byte;
            if (pos_reg >= OFS_UDP_BASE && pos_reg == udp_pos + 7'd1)
                hdr.udp_dport[7:0]  = item.frame_byte;
        end
    end

    assign pos_next = item.frame_end ? '0 : hdr.len;

    // Byte position, saturating at the end of the header window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (fire)
            pos_reg <= pos_next;
    end

    // Captured fields: payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            etype_reg  <= hdr.etype;
            tci_hi_reg <= hdr.tci_hi;
            proto_reg  <= hdr.ip_proto;
            dport_reg  <= hdr.udp_dport;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= HDR_LAST)
        else $error("byte position beyond header window");

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.frame_end) |=> (pos_reg == '0))
        else $error("byte position not cleared after final byte");

endmodule

[rtl/core/ts_packet_classifier_core.sv]
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall   in_item   (frame_byte, frame_end)
// out       out  out_valid / out_stall out_item  (flag, priority, totals)
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte item per cycle sustained unless a final byte waits on a stalled
// result: an input register feeds a single pass of field capture and decision
// into the result register; the 64-bit counter increment is the longest path.
// Reset clears the position and both counters and loads the register defaults;
// there is no clearing pass. A stalled result holds while non-final bytes flow on.
module ts_packet_classifier_core
    import tspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [63:0] norm_cnt_reg, norm_cnt_next;
    logic [63:0] ts_cnt_reg, ts_cnt_next;
    cfg_regs_t   cfg_reg;
    hdr_fields_t hdr;
    logic        adv, fire, done, ts;

    // Pipeline control: a non-final byte never waits on the output
    assign adv      = !in_item_reg.frame_end || !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && adv;
    assign done     = fire && in_item_reg.frame_end;
    assign in_stall = in_valid_reg && !adv;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    tspc_hdr_capture u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .hdr   (hdr)
    );

    // Decision and counter update
    assign ts            = classify(hdr, cfg_reg);
    assign norm_cnt_next = ts ? norm_cnt_reg : norm_cnt_reg + 64'd1;
    assign ts_cnt_next   = ts ? ts_cnt_reg + 64'd1 : ts_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_cnt_reg <= '0;
            ts_cnt_reg   <= '0;
        end
        else if (done)
        begin
            norm_cnt_reg <= norm_cnt_next;
            ts_cnt_reg   <= ts_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_item_reg.is_time_sensitive <= ts;
            out_item_reg.assigned_priority <= ts ? cfg_reg.ts_priority_value : 4'd0;
            out_item_reg.normal_total      <= norm_cnt_next;
            out_item_reg.ts_total          <= ts_cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avtp_type_value   <= RST_AVTP_TYPE;
            cfg_reg.pcp_threshold     <= RST_PCP_THRESH;
            cfg_reg.udp_match_port    <= RST_UDP_MATCH_PORT;
            cfg_reg.ts_priority_value <= RST_TS_PRIORITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AVTP_TYPE:      cfg_reg.avtp_type_value   <= cfg_data;
                CFG_PCP_THRESH:     cfg_reg.pcp_threshold     <= cfg_data[2:0];
                CFG_UDP_MATCH_PORT: cfg_reg.udp_match_port    <= cfg_data;
                CFG_TS_PRIORITY:    cfg_reg.ts_priority_value <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (norm_cnt_reg + ts_cnt_reg) ==
                 ($past(norm_cnt_reg) + $past(ts_cnt_reg) + 64'd1))
        else $error("frame counters did not advance by one");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(norm_cnt_reg) && $stable(ts_cnt_reg))
        else $error("frame counters moved without a final byte");

    a_prio_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.is_time_sensitive) |->
            (out_item_reg.assigned_priority == 4'd0))
        else $error("normal frame given a priority");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !done)
        else $error("result overwritten while stalled");

endmodule

[dv/tb_ts_packet_classifier_core.sv]
`timescale 1ns / 1ps

module tb_ts_packet_classifier_core;

    import tspc_pkg::*;

    // Longest frame built here and the bound on cycles without a handshake
    localparam int unsigned MAX_FRAME      = 160;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // Register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    // EtherType that matches none of the checks
    localparam logic [15:0] ETYPE_OTHER = 16'h86DD;

    typedef enum int unsigned {KIND_AVTP, KIND_VLAN, KIND_IPV4, KIND_NOISE} frame_kind_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Block ports, the inputs all known from time zero
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ts_packet_classifier_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Byte items waiting to go in, verdicts waiting to come out
    in_item_t  byte_items[$];
    out_item_t expected_verdicts[$];

    // Own copy of the classifier state
    cfg_regs_t   cfg_copy = '{RST_AVTP_TYPE, RST_PCP_THRESH, RST_UDP_MATCH_PORT,
                              RST_TS_PRIORITY};
    logic [7:0]  hdr_copy [0:HDR_BYTES-1];
    int unsigned hdr_fill      = 0;
    logic [63:0] normal_frames = '0;
    logic [63:0] ts_frames     = '0;

    // Run bookkeeping
    int unsigned mismatches     = 0;
    int unsigned frames_checked = 0;
    int unsigned ts_checked     = 0;
    int unsigned bytes_taken    = 0;
    int unsigned reg_writes     = 0;
    int unsigned settings       = 1;
    int unsigned stuck_cycles   = 0;
    bit          idling_on      = 1'b1;

    // Idle burst control, one set per side
    int unsigned in_gap        = 0;
    int unsigned in_calm_left  = 0;
    bit          in_bursty     = 1'b0;
    int unsigned out_hold      = 0;
    int unsigned out_calm_left = 0;
    bit          out_bursty    = 1'b0;

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Time-sensitive decision on the stored header of a frame of len bytes
    function automatic logic classify_frame(int unsigned len);
        logic [15:0] etype;
        int unsigned udp_off;
        if (len < LEN_ETH)
            return 1'b0;
        etype = {hdr_copy[OFS_ETYPE_HI], hdr_copy[OFS_ETYPE_LO]};
        if (etype == cfg_copy.avtp_type_value)
            return 1'b1;
        // VLAN: only the PCP counts, the inner EtherType is never looked at
        if (etype == ETYPE_VLAN)
            return (len >= LEN_VLAN) && (hdr_copy[OFS_TCI_HI][7:5] >= cfg_copy.pcp_threshold);
        if (etype != ETYPE_IPV4 || len < LEN_IPV4 || hdr_copy[OFS_IP_PROTO] != PROTO_UDP)
            return 1'b0;
        // UDP header sits straight after IHL words, even when IHL is below five
        udp_off = LEN_ETH + 4 * hdr_copy[OFS_TCI_HI][3:0];
        if (udp_off + 8 > len)
            return 1'b0;
        return {hdr_copy[udp_off + 2], hdr_copy[udp_off + 3]} == cfg_copy.udp_match_port;
    endfunction

    // Take one accepted byte; a final byte yields the expected verdict
    task automatic take_byte(in_item_t it);
        out_item_t verdict;
        logic      ts;
        bytes_taken++;
        if (hdr_fill < HDR_BYTES)
        begin
            hdr_copy[hdr_fill] = it.frame_byte;
            hdr_fill++;
        end
        if (it.frame_end)
        begin
            ts       = classify_frame(hdr_fill);
            hdr_fill = 0;
            if (ts)
                ts_frames++;
            else
                normal_frames++;
            verdict.is_time_sensitive = ts;
            verdict.assigned_priority = ts ? cfg_copy.ts_priority_value : 4'd0;
            verdict.normal_total      = normal_frames;
            verdict.ts_total          = ts_frames;
            expected_verdicts.push_back(verdict);
        end
    endtask

    task automatic check_verdict(out_item_t got);
        out_item_t want;
        if (expected_verdicts.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected: 0x%h", got));
            return;
        end
        want = expected_verdicts.pop_front();
        frames_checked++;
        if (want.is_time_sensitive)
            ts_checked++;
        if (got.is_time_sensitive !== want.is_time_sensitive)
            report_mismatch($sformatf("frame %0d is_time_sensitive %b, expected %b",
                frames_checked, got.is_time_sensitive, want.is_time_sensitive));
        if (got.assigned_priority !== want.assigned_priority)
            report_mismatch($sformatf("frame %0d assigned_priority %0d, expected %0d",
                frames_checked, got.assigned_priority, want.assigned_priority));
        if (got.normal_total !== want.normal_total)
            report_mismatch($sformatf("frame %0d normal_total %0d, expected %0d",
                frames_checked, got.normal_total, want.normal_total));
        if (got.ts_total !== want.ts_total)
            report_mismatch($sformatf("frame %0d ts_total %0d, expected %0d",
                frames_checked, got.ts_total, want.ts_total));
    endtask

    // Build a frame of random bytes with the decision fields placed, and queue it
    task automatic send_frame(logic [15:0] etype, logic [7:0] b14, logic [7:0] proto,
                              logic [15:0] dport, int unsigned len);
        logic [7:0]  frame_buf [0:MAX_FRAME-1];
        int unsigned dport_at;
        dport_at = LEN_ETH + 4 * b14[3:0] + 2;
        foreach (frame_buf[i])
            frame_buf[i] = 8'($urandom);
        {frame_buf[OFS_ETYPE_HI], frame_buf[OFS_ETYPE_LO]} = etype;
        frame_buf[OFS_TCI_HI]   = b14;
        frame_buf[OFS_IP_PROTO] = proto;
        {frame_buf[dport_at], frame_buf[dport_at + 1]} = dport;
        for (int unsigned i = 0; i < len; i++)
            byte_items.push_back('{frame_byte: frame_buf[i], frame_end: (i == len - 1)});
    endtask

    // Lengths cluster round the point where a check gets its bytes
    function automatic int unsigned pick_len(int unsigned need);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: return (need > 1) ? need - 1 : 1;
            4, 5, 6, 7: return need;
            19:         return $urandom_range(HDR_BYTES + 1, MAX_FRAME);
            default:    return $urandom_range(need, need + 12);
        endcase
    endfunction

    task automatic send_random_frame(output int unsigned len);
        frame_kind_t kind;
        logic [7:0]  b14;
        logic [7:0]  proto;
        logic [15:0] etype;
        logic [15:0] dport;
        int unsigned need;
        kind  = frame_kind_t'($urandom_range(0, 3));
        b14   = 8'($urandom);
        proto = ($urandom_range(0, 9) != 0) ? PROTO_UDP : 8'($urandom);
        dport = ($urandom_range(0, 3) != 0) ? cfg_copy.udp_match_port : 16'($urandom);
        case (kind)
            KIND_AVTP:
            begin
                etype = cfg_copy.avtp_type_value;
                need  = LEN_ETH;
            end
            KIND_VLAN:
            begin
                etype = ETYPE_VLAN;
                need  = LEN_VLAN;
            end
            KIND_IPV4:
            begin
                etype = ETYPE_IPV4;
                need  = LEN_UDP_BASE + 4 * b14[3:0];
                if (need < LEN_IPV4)
                    need = LEN_IPV4;
            end
            default:
            begin
                etype = 16'($urandom);
                need  = $urandom_range(1, 40);
            end
        endcase
        len = pick_len(need);
        send_frame(etype, b14, proto, dport, len);
    endtask

    task automatic random_phase(int unsigned byte_budget);
        int unsigned sent;
        int unsigned frames;
        int unsigned len;
        sent   = 0;
        frames = 0;
        while (sent < byte_budget || frames < 2)
        begin
            send_random_frame(len);
            sent += len;
            frames++;
        end
    endtask

    // Wait until every byte is in and every verdict out, then let the pipe settle
    task automatic drain();
        while (byte_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_AVTP_TYPE:      cfg_copy.avtp_type_value   = val;
            CFG_PCP_THRESH:     cfg_copy.pcp_threshold     = val[2:0];
            CFG_UDP_MATCH_PORT: cfg_copy.udp_match_port    = val;
            CFG_TS_PRIORITY:    cfg_copy.ts_priority_value = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] avtp, logic [15:0] pcp, logic [15:0] port,
                              logic [15:0] prio);
        write_reg(CFG_AVTP_TYPE, avtp);
        write_reg(CFG_PCP_THRESH, pcp);
        write_reg(CFG_UDP_MATCH_PORT, port);
        write_reg(CFG_TS_PRIORITY, prio);
        settings++;
    endtask

    // Input driver: takes accepted bytes into the predictor, then offers the next
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                take_byte(in_item);
            if (in_calm_left == 0)
            begin
                in_calm_left = $urandom_range(20, 80);
                in_bursty    = ($urandom_range(0, 2) != 0);
            end
            else
                in_calm_left--;
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (idling_on && in_bursty && $urandom_range(0, 99) < 12)
                begin
                    in_valid <= 1'b0;
                    in_gap = $urandom_range(0, 3);
                end
                else if (byte_items.size() != 0)
                begin
                    in_item  <= byte_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_verdict(out_item);
            if (out_calm_left == 0)
            begin
                out_calm_left = $urandom_range(20, 80);
                out_bursty    = ($urandom_range(0, 2) != 0);
            end
            else
                out_calm_left--;
            if (out_hold != 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else if (idling_on && out_bursty && $urandom_range(0, 99) < 15)
            begin
                out_stall <= 1'b1;
                out_hold = $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[%0t] watchdog: no handshake for %0d cycles, %0d verdicts pending",
                        $realtime, stuck_cycles, expected_verdicts.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset settings
        byte_items.push_back('{frame_byte: 8'h00, frame_end: 1'b1});
        byte_items.push_back('{frame_byte: 8'hFF, frame_end: 1'b1});
        // too short for the Ethernet header, then just long enough
        send_frame(cfg_copy.avtp_type_value, 8'h00, 8'h00, 16'h0000, 13);
        send_frame(cfg_copy.avtp_type_value, 8'hFF, 8'hFF, 16'hFFFF, 14);
        // VLAN: TCI missing, PCP at threshold, below it with AVTP inside, top PCP
        send_frame(ETYPE_VLAN, 8'hE0, PROTO_UDP, cfg_copy.udp_match_port, 15);
        send_frame(ETYPE_VLAN, 8'hA0, PROTO_UDP, cfg_copy.udp_match_port, 16);
        send_frame(ETYPE_VLAN, 8'h80, PROTO_UDP, cfg_copy.avtp_type_value, 18);
        send_frame(ETYPE_VLAN, 8'hFF, 8'h00, 16'h0000, 20);
        // IPv4: header cut short, UDP header cut short, full match, other port, not UDP
        send_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, cfg_copy.udp_match_port, 33);
        send_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, cfg_copy.udp_match_port, 41);
        send_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, cfg_copy.udp_match_port, 42);
        send_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, cfg_copy.udp_match_port + 16'd1, 42);
        send_frame(ETYPE_IPV4, 8'h45, 8'd6, cfg_copy.udp_match_port, 60);
        // IHL of zero puts the UDP header inside the IPv4 header
        send_frame(ETYPE_IPV4, 8'h40, PROTO_UDP, cfg_copy.udp_match_port, 34);
        // largest IHL: one byte short, exact, and beyond the stored window
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_UDP, cfg_copy.udp_match_port, 81);
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_UDP, cfg_copy.udp_match_port, 82);
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_UDP, cfg_copy.udp_match_port, 120);
        send_frame(ETYPE_OTHER, 8'h45, PROTO_UDP, cfg_copy.udp_match_port, 100);
        random_phase(55);
        drain();

        // Lowest settings, after writes to indexes that do not exist
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        write_reg(CFG_IDX_TOP, 16'h5A5A);
        set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_phase(55);
        drain();

        // Highest settings; spare data bits above each field set
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(55);
        drain();

        // AVTP value aliased onto VLAN, then onto IPv4
        set_config(ETYPE_VLAN, 16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(55);
        drain();

        set_config(ETYPE_IPV4, 16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(55);
        drain();

        // Closing stretch at full rate on both sides
        idling_on = 1'b0;
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(55);
        drain();

        repeat (8) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));

        $display("Checked %0d frame verdicts (%0d time-sensitive) from %0d byte items",
            frames_checked, ts_checked, bytes_taken);
        $display("%0d register writes over %0d settings, %0d mismatches",
            reg_writes, settings, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
